@@ rtl/pcet_pkg.sv @@
// Shared types, constants and defaults for the per-chip error threshold tracker.
package pcet_pkg;

    localparam int unsigned MAX_CHIPS_DEF  = 16;
    localparam int unsigned LINE_SHIFT_DEF = 6;

    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned SEL_W   = 4;
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned NCHIP_W = 5;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned IDX_W   = 6;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 72;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd6;
    localparam logic [NCHIP_W-1:0] NCHIP_RST = 5'd8;
    localparam logic [CNT_W-1:0]   THR_RST   = 16'd16;

    typedef enum logic [OP_W-1:0] {
        OP_ERROR     = 2'd0,
        OP_CLEAR_ALL = 2'd1,
        OP_CLEAR_ONE = 2'd2,
        OP_UNUSED    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_SHIFT  = 2'd0,
        REG_NCHIP  = 2'd1,
        REG_THRESH = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_UPDATE
    } t_state;

    // Control of the shared remainder unit.
    typedef struct packed {
        logic clr;
        logic step;
        logic din;
    } t_mod_ctl;

endpackage

@@ rtl/pcet_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pcet_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pcet_mod_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per step, MSB first.
module pcet_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcet_pkg::t_mod_ctl            i_ctl,
    input  logic [pcet_pkg::NCHIP_W-1:0]  i_divisor,
    output logic [pcet_pkg::NCHIP_W-1:0]  o_rem
);
    import pcet_pkg::*;

    logic [NCHIP_W-1:0] r_rem;
    logic [NCHIP_W-1:0] n_rem;
    logic [NCHIP_W:0]   w_trial;

    // Shift in one bit, subtract the divisor when it fits.
    always_comb begin
        w_trial = {r_rem, i_ctl.din};
        n_rem   = r_rem;
        if (i_ctl.clr) begin
            n_rem = '0;
        end else if (i_ctl.step) begin
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = NCHIP_W'(w_trial - {1'b0, i_divisor});
            end else begin
                n_rem = NCHIP_W'(w_trial);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

@@ rtl/per_chip_error_threshold_tracker.sv @@
// Top level of the per-chip correctable error threshold tracker.
//
// Requests arrive on the s_axis channel: tuser carries the opcode, tdata the
// physical address and the chip select. An error report is aligned down to
// a line, mapped to a chip by (line >> interleave_shift) mod chip_count and
// answered by one result on m_axis; interval and single-chip clears update
// state in the accept cycle and produce no result.
// An error report keeps the sequencer busy while its remainder is formed
// bit-serially by the shared remainder unit, one address bit per cycle from
// bit 47 down to bit interleave_shift; then the read state reads the counter
// RAM and the update state updates it and loads the result.
// s_axis_tready is high only while the sequencer is idle. The result sits in
// an output register, so the next request is taken while a result still
// waits; a stalled receiver only holds the update step once a second result
// is ready. Counters live in a RAM whose entries are qualified by per-chip
// valid bits, so a clear-all only has to clear the valid bits. Synchronous reset
// clears the valid bits, the pending marks, the sequencer and the output
// valid, and restores the register defaults. Registers sit on an APB port
// at byte addresses 0, 4 and 8; pready is always high.
module per_chip_error_threshold_tracker #(
    parameter int unsigned MAX_CHIPS  = pcet_pkg::MAX_CHIPS_DEF,
    parameter int unsigned LINE_SHIFT = pcet_pkg::LINE_SHIFT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [47:0] phys_address, [51:48] chip_select, [55:52] zero
    input  logic [pcet_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  logic [pcet_pkg::OP_W-1:0]        s_axis_tuser,
    // stream out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [47:0] line_address, [51:48] chip_id, [67:52] error_count,
    // [68] scrub_trigger, [71:69] zero
    output logic [pcet_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pcet_pkg::PADDR_W-1:0]     paddr,
    input  logic [pcet_pkg::PDATA_W-1:0]     pwdata,
    output logic [pcet_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import pcet_pkg::*;

    localparam int unsigned CW = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
    localparam logic [ADDR_W-1:0] LINE_MASK = ~((ADDR_W'(1) << LINE_SHIFT) - ADDR_W'(1));
    localparam logic [6:0] MAX_CHIPS_V = 7'(MAX_CHIPS);

    // ---------------- configuration registers ----------------
    logic [SHIFT_W-1:0] r_shift;
    logic [NCHIP_W-1:0] r_nchip;
    logic [CNT_W-1:0]   r_thresh;
    logic               w_cfg_wr;
    t_reg_idx           w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= SHIFT_RST;
            r_nchip  <= NCHIP_RST;
            r_thresh <= THR_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_SHIFT:  r_shift  <= pwdata[SHIFT_W-1:0];
                REG_NCHIP:  r_nchip  <= pwdata[NCHIP_W-1:0];
                REG_THRESH: r_thresh <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SHIFT:  prdata = PDATA_W'(r_shift);
            REG_NCHIP:  prdata = PDATA_W'(r_nchip);
            REG_THRESH: prdata = PDATA_W'(r_thresh);
            default:    prdata = '0;
        endcase
    end

    // Effective chip count: zero acts as one, clamp to MAX_CHIPS.
    logic [NCHIP_W-1:0] w_neff;
    always_comb begin
        if (r_nchip == '0) begin
            w_neff = NCHIP_W'(1);
        end else if ({2'b00, r_nchip} > MAX_CHIPS_V) begin
            w_neff = NCHIP_W'(MAX_CHIPS_V);
        end else begin
            w_neff = r_nchip;
        end
    end

    // ---------------- request decode ----------------
    t_state              r_state;
    t_state              n_state;
    logic                w_in_acc;
    t_opcode             w_op;
    logic [ADDR_W-1:0]   w_addr;
    logic [SEL_W-1:0]    w_sel;
    logic [IDX_W-1:0]    w_sel_ext;
    logic [CW-1:0]       w_sel_idx;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_opcode'(s_axis_tuser);
    assign w_addr        = s_axis_tdata[ADDR_W-1:0];
    assign w_sel         = s_axis_tdata[ADDR_W +: SEL_W];
    assign w_sel_ext     = IDX_W'(w_sel);
    assign w_sel_idx     = w_sel_ext[CW-1:0];

    // ---------------- datapath registers ----------------
    logic [ADDR_W-1:0]  r_line;
    logic [NCHIP_W-1:0] r_n;
    logic [IDX_W-1:0]   r_idx;
    logic               w_last_bit;

    assign w_last_bit = (r_idx == IDX_W'(r_shift));

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_op == OP_ERROR)) begin
            r_line <= w_addr & LINE_MASK;
            r_n    <= w_neff;
        end
        if (w_in_acc) begin
            r_idx <= IDX_W'(ADDR_W - 1);
        end else if (r_state == ST_MOD) begin
            r_idx <= r_idx - IDX_W'(1);
        end
    end

    // ---------------- shared remainder unit ----------------
    t_mod_ctl           w_mod_ctl;
    logic [NCHIP_W-1:0] w_rem;
    logic [IDX_W-1:0]   w_rem_ext;
    logic [CW-1:0]      w_chip;

    pcet_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mod_ctl),
        .i_divisor (r_n),
        .o_rem     (w_rem)
    );

    assign w_rem_ext = IDX_W'(w_rem);
    assign w_chip    = w_rem_ext[CW-1:0];

    // ---------------- counter store ----------------
    logic [MAX_CHIPS-1:0] r_cnt_vld;
    logic [MAX_CHIPS-1:0] r_pend;
    logic                 w_ram_we;
    logic [CNT_W-1:0]     w_ram_rdata;
    logic [CNT_W-1:0]     w_cnt_old;
    logic [CNT_W-1:0]     w_cnt_new;
    logic                 w_trig;

    pcet_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_CHIPS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_chip),
        .i_wdata (w_cnt_new),
        .i_raddr (w_chip),
        .o_rdata (w_ram_rdata)
    );

    // An entry without its valid bit reads as zero.
    assign w_cnt_old = r_cnt_vld[w_chip] ? w_ram_rdata : '0;
    assign w_cnt_new = (w_cnt_old == COUNT_MAX) ? w_cnt_old : w_cnt_old + CNT_W'(1);
    assign w_trig    = !r_pend[w_chip] && (w_cnt_new >= r_thresh);

    // ---------------- output register ----------------
    logic               r_m_valid;
    logic [ADDR_W-1:0]  r_o_line;
    logic [SEL_W-1:0]   r_o_chip;
    logic [CNT_W-1:0]   r_o_cnt;
    logic               r_o_trig;
    logic               w_out_free;
    logic               w_out_load;

    assign w_out_free = !r_m_valid || m_axis_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (w_op == OP_ERROR)) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (w_last_bit) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_mod_ctl  = '0;
        w_ram_we   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_mod_ctl.clr = w_in_acc && (w_op == OP_ERROR);
            end
            ST_MOD: begin
                w_mod_ctl.step = 1'b1;
                w_mod_ctl.din  = r_line[r_idx];
            end
            ST_UPDATE: begin
                w_ram_we   = w_out_free;
                w_out_load = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Valid bits and pending marks: valid-bit clears act at accept, updates at write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_pend    <= '0;
        end else begin
            if (w_in_acc && (w_op == OP_CLEAR_ALL)) begin
                r_cnt_vld <= '0;
            end else if (w_in_acc && (w_op == OP_CLEAR_ONE)
                         && ({1'b0, w_sel} < w_neff)) begin
                r_cnt_vld[w_sel_idx] <= 1'b0;
            end else if (w_ram_we) begin
                r_cnt_vld[w_chip] <= 1'b1;
            end
            if (w_ram_we && w_trig) begin
                r_pend[w_chip] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_line <= r_line;
            r_o_chip <= w_rem[SEL_W-1:0];
            r_o_cnt  <= w_cnt_new;
            r_o_trig <= w_trig;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_o_trig, r_o_cnt, r_o_chip, r_o_line};

endmodule

@@ rtl/pcet_checker.sv @@
// Port-level checker for the per-chip error threshold tracker, bound to the top level.
module pcet_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [pcet_pkg::OP_W-1:0]      s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pcet_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           psel,
    input logic                           penable,
    input logic                           pready
);
    import pcet_pkg::*;

    // Drop the output valid after reset.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Hold a stalled result.
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An error report keeps the block busy in the following cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_ERROR) |=> !s_axis_tready)
        else $error("ready right after an error report");

    // A scrub trigger comes with a nonzero count.
    a_trig_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[68] |-> m_axis_tdata[67:52] != '0)
        else $error("scrub trigger with zero count");

    // Keep the configuration port always ready.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("pready low during access");

endmodule

bind per_chip_error_threshold_tracker pcet_checker u_pcet_checker (.*);
